### src/fexlp_pkg.sv
// Package for the fill edge plotter: request/response types, codes and constants.
`default_nettype none
package fexlp_pkg;

   // Width of a computed pixel byte address: 511 rows * 255 stride + 127 bytes.
   localparam int ADDR_W = 17;

   localparam logic [1:0] FUNC_DRAW  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   localparam logic [7:0] STRIDE_RESET = 8'd40;
   localparam logic [7:0] PIX_MSB      = 8'h80;
   localparam logic [2:0] BIT_SEL_MASK = 3'd7;
   localparam int         BYTE_SHIFT   = 3;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  x_start;
      logic [8:0]  y_start;
      logic [9:0]  x_end;
      logic [8:0]  y_end;
      logic [13:0] byte_address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       address_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_STEP,
      ST_XOR,
      ST_RDWAIT
   } state_type;

endpackage
`default_nettype wire

### src/fexlp_plane_store.sv
// Bitplane byte store: one write port, one registered read port, clearing pass after reset.
`default_nettype none
module fexlp_plane_store #(
   parameter int PLANE_BYTES = 16384
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(PLANE_BYTES)-1:0] wr_addr,
   input  wire logic [7:0]                     wr_data,
   input  wire logic [$clog2(PLANE_BYTES)-1:0] rd_addr,
   output      logic [7:0]                     rd_data,
   output      logic                           clear_busy
);

   localparam int AW = $clog2(PLANE_BYTES);

   logic [7:0]    mem [PLANE_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] clr_in;
   logic          clearing_ff;
   logic          clearing_in;

   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == AW'(PLANE_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
      end
   end

   // sweep zeros first, then take user writes
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clearing_ff;

endmodule
`default_nettype wire

### src/fill_edge_xor_line_plotter.sv
// Top level of the fill edge plotter: command sequencer and edge walker over the bitplane store.
`default_nettype none
// After reset the store is swept to zero, with busy high; the stride register may be
// written meanwhile. One request is taken at a time: a read waits in ST_RDWAIT for the
// registered store output, a write or a rejected access answers at once, and a draw passes
// ST_SETUP, then ST_STEP for each step of the longer span plus ST_XOR for every pixel
// XOR-ed (each pixel is a read-modify-write over the store's read and write ports). Each
// request produces exactly one response, shown for one cycle under rsp_strobe from a register;
// the receiver cannot stall it, and the next request may be accepted in that same cycle.
module fill_edge_xor_line_plotter
   import fexlp_pkg::*;
#(
   parameter int PLANE_BYTES = 16384
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_item,
   output      logic    rsp_strobe,
   output      rsp_type rsp_item,
   input  wire logic    csr_valid,
   output      logic    csr_ready,
   input  wire logic [7:0] csr_data
);

   localparam int AW = $clog2(PLANE_BYTES);
   localparam logic [ADDR_W-1:0] PLANE_LIMIT = ADDR_W'(PLANE_BYTES);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [7:0]        stride_ff;
   logic [9:0]        col_ff, col_in;
   logic              dir_neg_ff, dir_neg_in;
   logic              steep_ff, steep_in;
   logic [9:0]        major_ff, major_in;
   logic [9:0]        minor_ff, minor_in;
   logic [10:0]       err_ff, err_in;
   logic [9:0]        cnt_ff, cnt_in;
   logic [ADDR_W-1:0] row_addr_ff, row_addr_in;
   logic              ovf_ff, ovf_in;
   logic [AW-1:0]     pix_addr_ff, pix_addr_in;
   logic [7:0]        pix_mask_ff, pix_mask_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [7:0]        wr_data;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        rd_data;
   logic              clear_busy;

   // request address checks
   logic [ADDR_W-1:0] req_addr_ext;
   logic              req_addr_bad;

   // edge setup terms
   logic              swap;
   logic [9:0]        xa, xb;
   logic [8:0]        ya, yb;
   logic [8:0]        dy;
   logic [9:0]        dx;
   logic              setup_steep;

   // walk step terms
   logic [10:0]       err_sum;
   logic              hit;
   logic              pix;
   logic              col_step;
   logic [ADDR_W-1:0] pix_addr;

   fexlp_plane_store #(
      .PLANE_BYTES(PLANE_BYTES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .clear_busy(clear_busy)
   );

   assign busy      = clear_busy | (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign req_addr_ext = ADDR_W'(req_item.byte_address);
   assign req_addr_bad = req_addr_ext >= PLANE_LIMIT;

   // order endpoints top to bottom and derive spans
   always_comb begin
      swap        = req_ff.y_start > req_ff.y_end;
      xa          = swap ? req_ff.x_end   : req_ff.x_start;
      ya          = swap ? req_ff.y_end   : req_ff.y_start;
      xb          = swap ? req_ff.x_start : req_ff.x_end;
      yb          = swap ? req_ff.y_start : req_ff.y_end;
      dy          = yb - ya;
      dx          = (xb < xa) ? (xa - xb) : (xb - xa);
      setup_steep = dx <= {1'b0, dy};
   end

   // one Bresenham step: steep edges plot every step and step sideways on a hit,
   // shallow edges step sideways every step and plot and move down on a hit
   always_comb begin
      err_sum  = err_ff + {1'b0, minor_ff};
      hit      = err_sum >= {1'b0, major_ff};
      pix      = steep_ff | hit;
      col_step = ~steep_ff | hit;
      pix_addr = row_addr_ff + ADDR_W'(col_ff >> BYTE_SHIFT);
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      col_in        = col_ff;
      dir_neg_in    = dir_neg_ff;
      steep_in      = steep_ff;
      major_in      = major_ff;
      minor_in      = minor_ff;
      err_in        = err_ff;
      cnt_in        = cnt_ff;
      row_addr_in   = row_addr_ff;
      ovf_in        = ovf_ff;
      pix_addr_in   = pix_addr_ff;
      pix_mask_in   = pix_mask_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      wr_en         = 1'b0;
      wr_addr       = pix_addr_ff;
      wr_data       = rd_data ^ pix_mask_ff;
      rd_addr       = pix_addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start && !clear_busy) begin
               req_in = req_item;
               case (req_item.func)
                  FUNC_DRAW: begin
                     state_in = ST_SETUP;
                  end
                  FUNC_READ: begin
                     if (req_addr_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_item_in   = '{read_data: 8'd0, address_overflow: 1'b1};
                     end else begin
                        rd_addr  = req_addr_ext[AW-1:0];
                        state_in = ST_RDWAIT;
                     end
                  end
                  FUNC_WRITE: begin
                     rsp_strobe_in = 1'b1;
                     rsp_item_in   = '{read_data: 8'd0, address_overflow: req_addr_bad};
                     if (!req_addr_bad) begin
                        wr_en   = 1'b1;
                        wr_addr = req_addr_ext[AW-1:0];
                        wr_data = req_item.write_data;
                     end
                  end
                  default: begin
                     // unused code: answer with zeros
                     rsp_strobe_in = 1'b1;
                     rsp_item_in   = '{read_data: 8'd0, address_overflow: 1'b0};
                  end
               endcase
            end
         end

         ST_RDWAIT: begin
            rsp_strobe_in = 1'b1;
            rsp_item_in   = '{read_data: rd_data, address_overflow: 1'b0};
            state_in      = ST_IDLE;
         end

         ST_SETUP: begin
            if (req_ff.y_start == req_ff.y_end) begin
               // equal rows: nothing to draw
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{read_data: 8'd0, address_overflow: 1'b0};
               state_in      = ST_IDLE;
            end else begin
               steep_in    = setup_steep;
               major_in    = setup_steep ? {1'b0, dy} : dx;
               minor_in    = setup_steep ? dx : {1'b0, dy};
               err_in      = setup_steep ? 11'(dy >> 1) : 11'(dx >> 1);
               cnt_in      = setup_steep ? {1'b0, dy} : dx;
               dir_neg_in  = xb < xa;
               col_in      = xa;
               row_addr_in = ADDR_W'(ya) * ADDR_W'(stride_ff);
               ovf_in      = 1'b0;
               state_in    = ST_STEP;
            end
         end

         ST_STEP: begin
            if (cnt_ff == 10'd0) begin
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{read_data: 8'd0, address_overflow: ovf_ff};
               state_in      = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 10'd1;
               err_in = hit ? (err_sum - {1'b0, major_ff}) : err_sum;
               if (col_step) begin
                  col_in = dir_neg_ff ? (col_ff - 10'd1) : (col_ff + 10'd1);
               end
               if (pix) begin
                  row_addr_in = row_addr_ff + ADDR_W'(stride_ff);
                  if (pix_addr >= PLANE_LIMIT) begin
                     // drop the pixel, flag it
                     ovf_in = 1'b1;
                  end else begin
                     pix_addr_in = pix_addr[AW-1:0];
                     pix_mask_in = PIX_MSB >> (col_ff[2:0] & BIT_SEL_MASK);
                     rd_addr     = pix_addr[AW-1:0];
                     state_in    = ST_XOR;
                  end
               end
            end
         end

         ST_XOR: begin
            // store byte arrives now: flip the bit and write back
            wr_en    = 1'b1;
            state_in = ST_STEP;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stride_ff     <= STRIDE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            stride_ff <= csr_data;
         end
      end
   end

   // payload and walker registers hold without reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      col_ff      <= col_in;
      dir_neg_ff  <= dir_neg_in;
      steep_ff    <= steep_in;
      major_ff    <= major_in;
      minor_ff    <= minor_in;
      err_ff      <= err_in;
      cnt_ff      <= cnt_in;
      row_addr_ff <= row_addr_in;
      ovf_ff      <= ovf_in;
      pix_addr_ff <= pix_addr_in;
      pix_mask_ff <= pix_mask_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
`default_nettype wire
